>>> hdl/cbi_pkg.sv
// cbi_pkg: shared sizes, codes, memory entry layouts and control structs
// for the code-block invalidation tracker.
// No dependencies; cbi_scan, cbi_check and the top refer to it by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package cbi_pkg;

    // table sizes
    localparam int SLOTS   = 1024;
    localparam int CHUNKS  = 512;
    localparam int MAX_OPS = 64;

    // fixed field widths of the item and result ports
    localparam int ACTION_W = 3;
    localparam int CIDX_W   = 9;
    localparam int DATA_W   = 64;
    localparam int SLOTIN_W = 10;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 7;
    localparam int DCNT_W   = 10;
    localparam int INV_W    = 11;
    localparam int FCNT_W   = 32;

    // derived widths
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CHUNK_W = $clog2(CHUNKS);
    localparam int DT_W    = $clog2(CHUNKS + 1);
    localparam int DIST_W  = $clog2(MAX_OPS + 1);
    // the sweep walks every word that has a slot or a chunk behind it
    localparam int SWEEP_N = (SLOTS > 2 * CHUNKS) ? SLOTS : 2 * CHUNKS;
    localparam int CNT_W   = $clog2(SWEEP_N);

    // range limits for 32-bit compares
    localparam logic [31:0] SLOTS_L  = 32'(SLOTS);
    localparam logic [31:0] CHUNKS_L = 32'(CHUNKS);

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 3'd0,
        ACT_RECORD = 3'd1,
        ACT_SYNC   = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    // slot status codes
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOCOMP   = 2'd1;
    localparam logic [STAT_W-1:0] ST_COMPILED = 2'd2;

    // slot table entry
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  len;
    } t_slot_ent;

    // shadow chunk entry, dirty flag kept next to the data
    typedef struct packed {
        logic              dirty;
        logic [DATA_W-1:0] data;
    } t_chunk_ent;

    // control from the sequencer to the sweep datapath
    typedef struct packed {
        logic start;     // new sweep: reset distance and kill count
        logic vld;       // a word's read data is present this cycle
        logic in_slots;  // the word has a slot
        logic dirty;     // the word's chunk is dirty
    } t_scan_ctl;

endpackage

>>> hdl/code_block_invalidation_top.sv
// Code-block invalidation tracker, top level: command sequencer, slot
// table and shadow memories, sweep pipeline.
// Depends on cbi_pkg, cbi_ram and cbi_scan.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Chunk load, record,
// read and the unused actions run in this way: the accept cycle issues the
// memory reads, the next cycle reads, modifies and writes back, and the
// result shows on o_done for one cycle right after, while the next item may
// already be accepted. A sync with nothing dirty runs the same way. A
// sync with dirty chunks walks all max(SLOTS, 2*CHUNKS) words, one a cycle
// through the read port of the slot and shadow memories, then passes a
// drain and a finish state before its result shows. A clear returns its
// result as those items do but then keeps busy high while it rewrites all
// SLOTS entries of the slot table. After reset, busy stays high for a
// clearing pass over all max(SLOTS, 2*CHUNKS) words that zeroes both
// memories. Results cannot be held off: o_done is high for exactly one
// cycle, and its fields are valid then and held until the next result.

module code_block_invalidation_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cbi_pkg::ACTION_W-1:0]  i_action,
    input  logic [cbi_pkg::CIDX_W-1:0]    i_chunk_index,
    input  logic [cbi_pkg::DATA_W-1:0]    i_chunk_data,
    input  logic [cbi_pkg::SLOTIN_W-1:0]  i_slot,
    input  logic [cbi_pkg::STAT_W-1:0]    i_slot_status,
    input  logic [cbi_pkg::LEN_W-1:0]     i_block_length,
    output logic                          o_done,
    output logic [cbi_pkg::STAT_W-1:0]    o_read_status,
    output logic [cbi_pkg::LEN_W-1:0]     o_read_length,
    output logic [cbi_pkg::DCNT_W-1:0]    o_dirty_count,
    output logic [cbi_pkg::INV_W-1:0]     o_invalidated_count,
    output logic                          o_flushed,
    output logic [cbi_pkg::FCNT_W-1:0]    o_flush_count
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_DRAIN,
        S_FINISH,
        S_CLEAR
    } t_state;

    localparam logic [cbi_pkg::CNT_W-1:0] CNT_SWEEP = cbi_pkg::CNT_W'(cbi_pkg::SWEEP_N - 1);
    localparam logic [cbi_pkg::CNT_W-1:0] CNT_SLOTS = cbi_pkg::CNT_W'(cbi_pkg::SLOTS - 1);
    localparam logic [cbi_pkg::LEN_W-1:0] LEN_MAX   = cbi_pkg::LEN_W'(cbi_pkg::MAX_OPS);

    // control registers
    t_state                       r_state, n_state;
    logic [cbi_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                         r_pv, n_pv;
    logic [cbi_pkg::CNT_W-1:0]    r_pword, n_pword;
    logic [cbi_pkg::DT_W-1:0]     r_dirty_total, n_dirty_total;
    logic [cbi_pkg::FCNT_W-1:0]   r_flush, n_flush;
    logic                         r_done, n_done;

    // latched item
    logic [cbi_pkg::ACTION_W-1:0] r_action;
    logic [cbi_pkg::CIDX_W-1:0]   r_cidx;
    logic [cbi_pkg::DATA_W-1:0]   r_cdata;
    logic [cbi_pkg::SLOTIN_W-1:0] r_slot;
    logic [cbi_pkg::STAT_W-1:0]   r_status;
    logic [cbi_pkg::LEN_W-1:0]    r_len;

    // result registers
    logic [cbi_pkg::STAT_W-1:0]   r_rstat, n_rstat;
    logic [cbi_pkg::LEN_W-1:0]    r_rlen, n_rlen;
    logic [cbi_pkg::DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic [cbi_pkg::INV_W-1:0]    r_inval, n_inval;
    logic                         r_flushed, n_flushed;

    // memory ports
    logic                         sr_re, sw_we;
    logic [cbi_pkg::SLOT_W-1:0]   sr_raddr, sw_waddr;
    cbi_pkg::t_slot_ent           sr_rdata, sw_wdata;
    logic                         hr_re, hw_we;
    logic [cbi_pkg::CHUNK_W-1:0]  hr_raddr, hw_waddr;
    cbi_pkg::t_chunk_ent          hr_rdata, hw_wdata;

    // sweep datapath
    cbi_pkg::t_scan_ctl           scan_ctl;
    logic                         kill;
    logic [cbi_pkg::INV_W-1:0]    kills;

    logic accept, slot_ok, chunk_ok, differ;
    logic p_in_slots, p_chunk_ok, c_in_slots, c_chunk_ok;

    assign accept     = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign slot_ok    = 32'(r_slot) < cbi_pkg::SLOTS_L;
    assign chunk_ok   = 32'(r_cidx) < cbi_pkg::CHUNKS_L;
    assign differ     = hr_rdata.data != r_cdata;
    assign p_in_slots = 32'(r_pword) < cbi_pkg::SLOTS_L;
    assign p_chunk_ok = (32'(r_pword) >> 1) < cbi_pkg::CHUNKS_L;
    assign c_in_slots = 32'(r_cnt) < cbi_pkg::SLOTS_L;
    assign c_chunk_ok = (32'(r_cnt) >> 1) < cbi_pkg::CHUNKS_L;

    cbi_ram #(
        .WIDTH ($bits(cbi_pkg::t_slot_ent)),
        .DEPTH (cbi_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sw_we),
        .i_waddr (sw_waddr),
        .i_wdata (sw_wdata),
        .i_re    (sr_re),
        .i_raddr (sr_raddr),
        .o_rdata (sr_rdata)
    );

    cbi_ram #(
        .WIDTH ($bits(cbi_pkg::t_chunk_ent)),
        .DEPTH (cbi_pkg::CHUNKS)
    ) u_shadow_ram (
        .i_clk   (i_clk),
        .i_we    (hw_we),
        .i_waddr (hw_waddr),
        .i_wdata (hw_wdata),
        .i_re    (hr_re),
        .i_raddr (hr_raddr),
        .o_rdata (hr_rdata)
    );

    assign scan_ctl.start    = (r_state == S_EXEC) && (r_action == cbi_pkg::ACT_SYNC) &&
                               (r_dirty_total != '0);
    assign scan_ctl.vld      = r_pv;
    assign scan_ctl.in_slots = p_in_slots;
    assign scan_ctl.dirty    = p_chunk_ok && hr_rdata.dirty;

    cbi_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_ent   (sr_rdata),
        .o_kill  (kill),
        .o_kills (kills)
    );

    // memory access control
    always_comb begin
        sr_re    = 1'b0;
        sr_raddr = '0;
        sw_we    = 1'b0;
        sw_waddr = '0;
        sw_wdata = '0;
        hr_re    = 1'b0;
        hr_raddr = '0;
        hw_we    = 1'b0;
        hw_waddr = '0;
        hw_wdata = '0;
        case (r_state)
            S_INIT: begin
                // clearing pass over both memories
                sw_we    = c_in_slots;
                sw_waddr = r_cnt[cbi_pkg::SLOT_W-1:0];
                hw_we    = c_chunk_ok && !r_cnt[0];
                hw_waddr = r_cnt[cbi_pkg::CHUNK_W:1];
            end
            S_IDLE: begin
                // reads for the incoming item
                sr_re    = start;
                sr_raddr = cbi_pkg::SLOT_W'(i_slot);
                hr_re    = start;
                hr_raddr = cbi_pkg::CHUNK_W'(i_chunk_index);
            end
            S_EXEC: begin
                case (r_action)
                    cbi_pkg::ACT_LOAD: begin
                        hw_we         = chunk_ok && differ;
                        hw_waddr      = cbi_pkg::CHUNK_W'(r_cidx);
                        hw_wdata.dirty = 1'b1;
                        hw_wdata.data  = r_cdata;
                    end
                    cbi_pkg::ACT_RECORD: begin
                        sw_we    = slot_ok;
                        sw_waddr = cbi_pkg::SLOT_W'(r_slot);
                        if (r_status == cbi_pkg::ST_COMPILED) begin
                            sw_wdata.status = cbi_pkg::ST_COMPILED;
                            sw_wdata.len    = (r_len > LEN_MAX) ? LEN_MAX : r_len;
                        end else if (r_status == cbi_pkg::ST_NOCOMP) begin
                            sw_wdata.status = cbi_pkg::ST_NOCOMP;
                            sw_wdata.len    = '0;
                        end else begin
                            sw_wdata.status = cbi_pkg::ST_UNKNOWN;
                            sw_wdata.len    = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SWEEP: begin
                sr_re    = c_in_slots;
                sr_raddr = r_cnt[cbi_pkg::SLOT_W-1:0];
                hr_re    = c_chunk_ok;
                hr_raddr = r_cnt[cbi_pkg::CHUNK_W:1];
            end
            S_CLEAR: begin
                sw_we    = 1'b1;
                sw_waddr = r_cnt[cbi_pkg::SLOT_W-1:0];
            end
            default: begin
            end
        endcase

        // sweep write-back: killed slot, and chunk clean on its lower word
        if (r_pv) begin
            sw_we          = kill;
            sw_waddr       = r_pword[cbi_pkg::SLOT_W-1:0];
            sw_wdata       = '0;
            hw_we          = p_chunk_ok && !r_pword[0];
            hw_waddr       = r_pword[cbi_pkg::CHUNK_W:1];
            hw_wdata.dirty = 1'b0;
            hw_wdata.data  = hr_rdata.data;
        end
    end

    // sequencer next state and results
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_pv          = 1'b0;
        n_pword       = r_pword;
        n_dirty_total = r_dirty_total;
        n_flush       = r_flush;
        n_done        = 1'b0;
        n_rstat       = '0;
        n_rlen        = '0;
        n_dcnt        = '0;
        n_inval       = '0;
        n_flushed     = 1'b0;
        case (r_state)
            S_INIT: begin
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - cbi_pkg::CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_action)
                    cbi_pkg::ACT_LOAD: begin
                        if (chunk_ok && differ && !hr_rdata.dirty) begin
                            n_dirty_total = r_dirty_total + cbi_pkg::DT_W'(1);
                        end
                    end
                    cbi_pkg::ACT_SYNC: begin
                        if (r_dirty_total != '0) begin
                            n_state = S_SWEEP;
                            n_cnt   = CNT_SWEEP;
                            n_done  = 1'b0;
                        end
                    end
                    cbi_pkg::ACT_CLEAR: begin
                        n_state   = S_CLEAR;
                        n_cnt     = CNT_SLOTS;
                        n_flush   = r_flush + cbi_pkg::FCNT_W'(1);
                        n_flushed = 1'b1;
                    end
                    cbi_pkg::ACT_READ: begin
                        if (slot_ok) begin
                            n_rstat = sr_rdata.status;
                            n_rlen  = sr_rdata.len;
                        end
                    end
                    default: begin
                    end
                endcase
                n_dcnt = cbi_pkg::DCNT_W'(n_dirty_total);
            end
            S_SWEEP: begin
                n_pv    = 1'b1;
                n_pword = r_cnt;
                if (r_cnt == '0) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt - cbi_pkg::CNT_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state       = S_IDLE;
                n_done        = 1'b1;
                n_dcnt        = cbi_pkg::DCNT_W'(r_dirty_total);
                n_inval       = kills;
                n_flushed     = 1'b1;
                n_flush       = r_flush + cbi_pkg::FCNT_W'(1);
                n_dirty_total = '0;
            end
            S_CLEAR: begin
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - cbi_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, counters and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_cnt         <= CNT_SWEEP;
            r_pv          <= 1'b0;
            r_dirty_total <= '0;
            r_flush       <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_pv          <= n_pv;
            r_pword       <= n_pword;
            r_dirty_total <= n_dirty_total;
            r_flush       <= n_flush;
            r_done        <= n_done;
            if (n_done) begin
                r_rstat   <= n_rstat;
                r_rlen    <= n_rlen;
                r_dcnt    <= n_dcnt;
                r_inval   <= n_inval;
                r_flushed <= n_flushed;
            end
            if (accept) begin
                r_action <= i_action;
                r_cidx   <= i_chunk_index;
                r_cdata  <= i_chunk_data;
                r_slot   <= i_slot;
                r_status <= i_slot_status;
                r_len    <= i_block_length;
            end
        end
    end

    assign o_done              = r_done;
    assign o_read_status       = r_rstat;
    assign o_read_length       = r_rlen;
    assign o_dirty_count       = r_dcnt;
    assign o_invalidated_count = r_inval;
    assign o_flushed           = r_flushed;
    assign o_flush_count       = r_flush;

endmodule

>>> hdl/cbi_ram.sv
// cbi_ram: simple dual-port synchronous RAM, one write and one read port,
// read data registered. No dependencies.
`timescale 1ns / 1ps

module cbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/cbi_scan.sv
// cbi_scan: sweep datapath. Walks words from the top down, tracks the
// distance to the nearest dirty word at or above, and decides slot kills.
// Depends on cbi_pkg.
`timescale 1ns / 1ps

module cbi_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cbi_pkg::t_scan_ctl    i_ctl,
    input  cbi_pkg::t_slot_ent    i_ent,
    output logic                  o_kill,
    output logic [cbi_pkg::INV_W-1:0] o_kills
);

    localparam logic [cbi_pkg::DIST_W-1:0] DIST_MAX = cbi_pkg::DIST_W'(cbi_pkg::MAX_OPS);

    logic [cbi_pkg::DIST_W-1:0] r_dist;
    logic [cbi_pkg::INV_W-1:0]  r_kills;
    logic [cbi_pkg::DIST_W-1:0] n_dist;
    logic [cbi_pkg::DIST_W-1:0] cov_len;

    // distance to nearest dirty word, saturating at MAX_OPS (none in reach)
    always_comb begin
        if (i_ctl.dirty && i_ctl.in_slots) begin
            n_dist = '0;
        end else if (r_dist == DIST_MAX) begin
            n_dist = r_dist;
        end else begin
            n_dist = r_dist + cbi_pkg::DIST_W'(1);
        end
    end

    // coverage: stored length when compiled, MAX_OPS otherwise
    assign cov_len = (i_ent.status == cbi_pkg::ST_COMPILED) ?
                     cbi_pkg::DIST_W'(i_ent.len) : DIST_MAX;
    assign o_kill  = i_ctl.vld && i_ctl.in_slots &&
                     (i_ent.status != cbi_pkg::ST_UNKNOWN) && (n_dist < cov_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= DIST_MAX;
            r_kills <= '0;
        end else if (i_ctl.start) begin
            r_dist  <= DIST_MAX;
            r_kills <= '0;
        end else if (i_ctl.vld) begin
            r_dist  <= n_dist;
            r_kills <= r_kills + cbi_pkg::INV_W'(o_kill);
        end
    end

    assign o_kills = r_kills;

endmodule

>>> hdl/cbi_check.sv
// cbi_check: port-level checks for the code-block invalidation tracker,
// bound to code_block_invalidation_top. Depends on cbi_pkg.
`timescale 1ns / 1ps

module cbi_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_done,
    input logic [cbi_pkg::INV_W-1:0]     o_invalidated_count,
    input logic                          o_flushed,
    input logic [cbi_pkg::FCNT_W-1:0]    o_flush_count
);

    // an accepted item makes the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low right after an accepted item");

    // results are spaced: o_done never comes on consecutive cycles
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe on two cycles in a row");

    // the flush counter moves only with a flushing result, by one
    a_flush_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_flush_count != $past(o_flush_count)) |->
            o_done && o_flushed && (o_flush_count == $past(o_flush_count) + 32'd1))
        else $error("flush count changed without a flushing result");

    // slots can only be invalidated by a sweep that counts as a flush
    a_inval_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_invalidated_count != '0) |-> o_flushed)
        else $error("invalidations reported without a flush");

endmodule

bind code_block_invalidation_top cbi_check u_cbi_check (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_done              (o_done),
    .o_invalidated_count (o_invalidated_count),
    .o_flushed           (o_flushed),
    .o_flush_count       (o_flush_count)
);

>>> sim/tb_code_block_invalidation_top.sv
// Self-checking testbench for code_block_invalidation_top: directed and random
// commands go through the start/busy handshake and each o_done result is checked.
// Depends on cbi_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_code_block_invalidation_top;
    import cbi_pkg::*;

    // action codes the block decodes as no-ops
    localparam logic [ACTION_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD7 = 3'd7;
    // status code that is stored as unknown
    localparam logic [STAT_W-1:0] ST_RESERVED = 2'd3;

    localparam int TARGET_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SETTLE       = 1100;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [CIDX_W-1:0]   chunk_index;
        logic [DATA_W-1:0]   chunk_data;
        logic [SLOTIN_W-1:0] slot;
        logic [STAT_W-1:0]   slot_status;
        logic [LEN_W-1:0]    block_length;
        int unsigned         idle_pct;
        bit                  drain;
    } command_t;

    typedef struct {
        logic [STAT_W-1:0] read_status;
        logic [LEN_W-1:0]  read_length;
        logic [DCNT_W-1:0] dirty_count;
        logic [INV_W-1:0]  invalidated_count;
        logic              flushed;
        logic [FCNT_W-1:0] flush_count;
    } result_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] i_action;
    logic [CIDX_W-1:0]   i_chunk_index;
    logic [DATA_W-1:0]   i_chunk_data;
    logic [SLOTIN_W-1:0] i_slot;
    logic [STAT_W-1:0]   i_slot_status;
    logic [LEN_W-1:0]    i_block_length;
    logic                o_done;
    logic [STAT_W-1:0]   o_read_status;
    logic [LEN_W-1:0]    o_read_length;
    logic [DCNT_W-1:0]   o_dirty_count;
    logic [INV_W-1:0]    o_invalidated_count;
    logic                o_flushed;
    logic [FCNT_W-1:0]   o_flush_count;

    code_block_invalidation_top u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_action            (i_action),
        .i_chunk_index       (i_chunk_index),
        .i_chunk_data        (i_chunk_data),
        .i_slot              (i_slot),
        .i_slot_status       (i_slot_status),
        .i_block_length      (i_block_length),
        .o_done              (o_done),
        .o_read_status       (o_read_status),
        .o_read_length       (o_read_length),
        .o_dirty_count       (o_dirty_count),
        .o_invalidated_count (o_invalidated_count),
        .o_flushed           (o_flushed),
        .o_flush_count       (o_flush_count)
    );

    // tracker state mirrored by the predictor
    logic [DATA_W-1:0] shadow_mem  [CHUNKS];
    bit                chunk_dirty [CHUNKS];
    logic [STAT_W-1:0] slot_state  [SLOTS];
    logic [LEN_W-1:0]  slot_len    [SLOTS];
    logic [DCNT_W-1:0] dirty_chunks;
    logic [FCNT_W-1:0] flushes;

    command_t    pending_cmds[$];
    result_t     expected_results[$];
    int unsigned fill_idle;
    int unsigned items_queued;
    int unsigned items_taken;
    int unsigned results_checked;
    int unsigned dirty_sweeps;
    int unsigned slots_killed;
    int unsigned table_clears;
    int unsigned error_count;
    int unsigned cycle_count;
    bit          item_taken;
    bit          launch;
    command_t    drv_cmd;
    command_t    mon_cmd;

    // applies one command to the mirrored state and returns the result it owes
    function automatic result_t apply_command(command_t c);
        result_t     r;
        int unsigned prefix [SLOTS+1];
        int unsigned n;
        int unsigned stop;
        int unsigned kills;
        r = '{default: '0};
        case (c.action)
            ACT_LOAD: begin
                if (int'(c.chunk_index) < CHUNKS && shadow_mem[c.chunk_index] != c.chunk_data) begin
                    if (!chunk_dirty[c.chunk_index]) begin
                        chunk_dirty[c.chunk_index] = 1'b1;
                        dirty_chunks++;
                    end
                    shadow_mem[c.chunk_index] = c.chunk_data;
                end
            end
            ACT_RECORD: begin
                if (int'(c.slot) < SLOTS) begin
                    if (c.slot_status == ST_COMPILED) begin
                        slot_state[c.slot] = ST_COMPILED;
                        slot_len[c.slot]   = (c.block_length > MAX_OPS) ? LEN_W'(MAX_OPS)
                                                                        : c.block_length;
                    end else begin
                        slot_state[c.slot] = (c.slot_status == ST_NOCOMP) ? ST_NOCOMP : ST_UNKNOWN;
                        slot_len[c.slot]   = '0;
                    end
                end
            end
            ACT_CLEAR: begin
                foreach (slot_state[i]) begin
                    slot_state[i] = ST_UNKNOWN;
                    slot_len[i]   = '0;
                end
                flushes++;
                r.flushed = 1'b1;
                table_clears++;
            end
            ACT_READ: begin
                if (int'(c.slot) < SLOTS) begin
                    r.read_status = slot_state[c.slot];
                    r.read_length = slot_len[c.slot];
                end
            end
            default: ;
        endcase
        r.dirty_count = dirty_chunks;
        // sync: kill every known slot whose coverage touches a dirty word
        if (c.action == ACT_SYNC) begin
            if (dirty_chunks != 0) begin
                prefix[0] = 0;
                for (int w = 0; w < SLOTS; w++)
                    prefix[w+1] = prefix[w] + ((w / 2 < CHUNKS && chunk_dirty[w / 2]) ? 1 : 0);
                kills = 0;
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_state[s] != ST_UNKNOWN) begin
                        n    = (slot_state[s] == ST_COMPILED) ? slot_len[s] : MAX_OPS;
                        stop = (s + n > SLOTS) ? SLOTS : s + n;
                        if (prefix[stop] != prefix[s]) begin
                            slot_state[s] = ST_UNKNOWN;
                            slot_len[s]   = '0;
                            kills++;
                        end
                    end
                end
                flushes++;
                r.flushed           = 1'b1;
                r.invalidated_count = INV_W'(kills);
                dirty_sweeps++;
                slots_killed += kills;
            end
            foreach (chunk_dirty[i]) chunk_dirty[i] = 1'b0;
            dirty_chunks = '0;
        end
        r.flush_count = flushes;
        return r;
    endfunction

    // command with every item field random, action given; no idle share, no drain
    function automatic command_t rand_cmd(logic [ACTION_W-1:0] act);
        command_t c;
        c.action       = act;
        c.chunk_index  = CIDX_W'($urandom);
        c.chunk_data   = {$urandom, $urandom};
        c.slot         = SLOTIN_W'($urandom);
        c.slot_status  = STAT_W'($urandom);
        c.block_length = LEN_W'($urandom);
        c.idle_pct     = 0;
        c.drain        = 1'b0;
        return c;
    endfunction

    task automatic queue_cmd(command_t c);
        c.idle_pct = fill_idle;
        pending_cmds.push_back(c);
        items_queued++;
    endtask

    task automatic queue_load(int unsigned cidx, logic [DATA_W-1:0] data);
        command_t c;
        c             = rand_cmd(ACT_LOAD);
        c.chunk_index = CIDX_W'(cidx);
        c.chunk_data  = data;
        queue_cmd(c);
    endtask

    task automatic queue_record(int unsigned s, logic [STAT_W-1:0] st, int unsigned len);
        command_t c;
        c              = rand_cmd(ACT_RECORD);
        c.slot         = SLOTIN_W'(s);
        c.slot_status  = st;
        c.block_length = LEN_W'(len);
        queue_cmd(c);
    endtask

    task automatic queue_read(int unsigned s);
        command_t c;
        c      = rand_cmd(ACT_READ);
        c.slot = SLOTIN_W'(s);
        queue_cmd(c);
    endtask

    // sender holds off until every outstanding result has come back
    task automatic queue_drain();
        command_t c;
        c       = rand_cmd(ACT_RSVD7);
        c.drain = 1'b1;
        pending_cmds.push_back(c);
    endtask

    task automatic check_result(result_t e);
        if (o_read_status !== e.read_status) begin
            $error("read_status expected %0d got %0d", e.read_status, o_read_status);
            error_count++;
        end
        if (o_read_length !== e.read_length) begin
            $error("read_length expected %0d got %0d", e.read_length, o_read_length);
            error_count++;
        end
        if (o_dirty_count !== e.dirty_count) begin
            $error("dirty_count expected %0d got %0d", e.dirty_count, o_dirty_count);
            error_count++;
        end
        if (o_invalidated_count !== e.invalidated_count) begin
            $error("invalidated_count expected %0d got %0d",
                   e.invalidated_count, o_invalidated_count);
            error_count++;
        end
        if (o_flushed !== e.flushed) begin
            $error("flushed expected %0d got %0d", e.flushed, o_flushed);
            error_count++;
        end
        if (o_flush_count !== e.flush_count) begin
            $error("flush_count expected %0d got %0d", e.flush_count, o_flush_count);
            error_count++;
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("code_block_invalidation_top: mismatch");
            $finish;
        end
    end

    // driver: present the next item at the falling edge, hold it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !item_taken)) begin
            launch = 1'b0;
            if (pending_cmds.size() != 0) begin
                if (pending_cmds[0].drain) begin
                    if (expected_results.size() == 0)
                        void'(pending_cmds.pop_front());
                end else if ($urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
                    drv_cmd        = pending_cmds.pop_front();
                    i_action       <= drv_cmd.action;
                    i_chunk_index  <= drv_cmd.chunk_index;
                    i_chunk_data   <= drv_cmd.chunk_data;
                    i_slot         <= drv_cmd.slot;
                    i_slot_status  <= drv_cmd.slot_status;
                    i_block_length <= drv_cmd.block_length;
                    launch = 1'b1;
                end
            end
            start <= launch;
        end
    end

    // monitor: predict on acceptance first, then check any result strobe
    always @(posedge i_clk) begin
        item_taken = i_rst_n && start && !busy;
        if (item_taken) begin
            mon_cmd              = rand_cmd(i_action);
            mon_cmd.chunk_index  = i_chunk_index;
            mon_cmd.chunk_data   = i_chunk_data;
            mon_cmd.slot         = i_slot;
            mon_cmd.slot_status  = i_slot_status;
            mon_cmd.block_length = i_block_length;
            expected_results.push_back(apply_command(mon_cmd));
            items_taken++;
        end
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result strobe with no item outstanding");
                error_count++;
            end else begin
                check_result(expected_results.pop_front());
                results_checked++;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned phase_pct [3];
        int unsigned base;
        int unsigned roll;
        int unsigned cidx;
        int unsigned st_roll;
        logic [STAT_W-1:0] st;
        int unsigned len;
        logic [DATA_W-1:0] data;

        phase_pct = '{0, 58, 30};
        start          <= 1'b0;
        i_rst_n        <= 1'b0;
        i_action       <= ACT_RSVD7;
        i_chunk_index  <= '0;
        i_chunk_data   <= '0;
        i_slot         <= '0;
        i_slot_status  <= ST_UNKNOWN;
        i_block_length <= '0;
        item_taken     = 1'b0;
        foreach (shadow_mem[i]) begin
            shadow_mem[i]  = '0;
            chunk_dirty[i] = 1'b0;
        end
        foreach (slot_state[i]) begin
            slot_state[i] = ST_UNKNOWN;
            slot_len[i]   = '0;
        end
        dirty_chunks = '0;
        flushes      = '0;
        fill_idle    = 0;

        // directed: reset contents, record corner cases, dirty sweep, clean sync, clear
        queue_read(0);
        queue_record(0, ST_COMPILED, MAX_OPS);
        queue_record(SLOTS - 1, ST_COMPILED, 127);      // saturates to MAX_OPS
        queue_record(5, ST_RESERVED, 9);                // stores unknown
        queue_record(10, ST_NOCOMP, 50);                // length dropped
        queue_record(20, ST_COMPILED, 0);               // empty coverage
        queue_record(100, ST_COMPILED, 1);
        queue_read(SLOTS - 1);
        queue_read(5);
        queue_read(10);
        queue_load(0, '0);                              // same as shadow, stays clean
        queue_load(CHUNKS - 1, '1);
        queue_load(CHUNKS - 1, '1);                     // unchanged reload
        queue_load(CHUNKS - 1, 64'h5555_aaaa_5555_aaaa);// changes again, counted once
        queue_load(10, 64'h0123_4567_89ab_cdef);
        queue_cmd(rand_cmd(ACT_SYNC));
        queue_read(0);
        queue_read(20);
        queue_read(10);
        queue_cmd(rand_cmd(ACT_SYNC));                  // nothing dirty
        queue_cmd(rand_cmd(ACT_CLEAR));
        queue_read(100);
        queue_cmd(rand_cmd(ACT_RSVD5));
        queue_cmd(rand_cmd(ACT_RSVD6));
        queue_cmd(rand_cmd(ACT_RSVD7));
        queue_drain();

        // random: mostly record / load / sync / read episodes around one region
        while (items_queued < TARGET_ITEMS) begin
            fill_idle = phase_pct[(items_queued / 150) % 3];
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                base = $urandom_range(0, SLOTS - 1);
                repeat ($urandom_range(2, 12)) begin
                    st_roll = $urandom_range(0, 9);
                    st  = (st_roll < 5) ? ST_COMPILED : (st_roll < 8) ? ST_NOCOMP :
                          (st_roll < 9) ? ST_UNKNOWN : ST_RESERVED;
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_OPS + 1, 127)
                                                      : $urandom_range(0, MAX_OPS);
                    queue_record((base + $urandom_range(0, 95)) % SLOTS, st, len);
                end
                repeat ($urandom_range(1, 4)) begin
                    cidx = ((base + $urandom_range(0, 127)) / 2) % CHUNKS;
                    case ($urandom_range(0, 3))
                        0:       data = '0;
                        1:       data = '1;
                        default: data = {$urandom, $urandom};
                    endcase
                    queue_load(cidx, data);
                    if ($urandom_range(0, 3) == 0)
                        queue_load(cidx, data);
                end
                repeat ($urandom_range(0, 2))
                    queue_read((base + $urandom_range(0, 95)) % SLOTS);
                queue_cmd(rand_cmd(ACT_SYNC));
                repeat ($urandom_range(1, 4))
                    queue_read((base + $urandom_range(0, 95)) % SLOTS);
            end else if (roll < 83) begin
                queue_cmd(rand_cmd(ACT_CLEAR));
            end else if (roll < 85) begin
                queue_drain();
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(rand_cmd(ACT_LOAD + ACTION_W'($urandom_range(0, 7))));
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("%0d items taken, %0d results checked in %0d cycles", items_taken,
                 results_checked, cycle_count);
        $display("%0d dirty sweeps reset %0d slots; %0d table clears", dirty_sweeps,
                 slots_killed, table_clears);
        if (error_count == 0)
            $display("code_block_invalidation_top: match");
        else
            $display("code_block_invalidation_top: mismatch");
        $finish;
    end

endmodule

>>> files.f
hdl/cbi_pkg.sv
hdl/cbi_ram.sv
hdl/cbi_scan.sv
hdl/code_block_invalidation_top.sv
hdl/cbi_check.sv
sim/tb_code_block_invalidation_top.sv
